/* sv/achb_pkg.sv */
// Shared types, constants and codes of the auto-clearing histogram binner.
`default_nettype none

package achb_pkg;

  // Default bin count and field widths.
  localparam int BINS_DEF = 64;
  localparam int SAMPLE_W = 32;
  localparam int BINW_W   = 26;
  localparam int LIMIT_W  = 16;
  localparam int SEL_W    = 6;
  localparam int CNT_W    = 17;

  // Bin counts stop here.
  localparam logic [CNT_W-1:0] COUNT_MAX = 17'd65536;

  // Clear generation tag kept beside each count in the store.
  localparam int EPOCH_W = 4;

  // Register port geometry.
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  // Register reset values.
  localparam logic signed [SAMPLE_W-1:0] RANGE_LOW_RST   = 32'sd19660800;
  localparam logic [BINW_W-1:0]          BIN_WIDTH_RST   = 26'd61440;
  localparam logic [LIMIT_W-1:0]         COUNT_LIMIT_RST = 16'd48;

  // Register indexes (byte address divided by four).
  typedef enum logic [1:0] {
    REG_RANGE_LOW   = 2'd0,
    REG_BIN_WIDTH   = 2'd1,
    REG_COUNT_LIMIT = 2'd2
  } reg_idx_t;

  // Item kinds.
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_READ   = 1'b1;

  // Input word.
  typedef struct packed {
    logic                       kind;
    logic signed [SAMPLE_W-1:0] sample_value;
    logic [SEL_W-1:0]           bin_select;
  } in_word_t;

  // Result word.
  typedef struct packed {
    logic [SEL_W-1:0] bin_index;
    logic [CNT_W-1:0] bin_count;
    logic [CNT_W-1:0] peak_count;
    logic             cleared;
  } out_word_t;

  // Register contents handed to the datapath.
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] range_low;
    logic [BINW_W-1:0]          bin_width;
    logic [LIMIT_W-1:0]         count_limit;
    logic                       edges_wr;
  } cfg_regs_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_PREP,
    ST_RANGE,
    ST_DIV,
    ST_RD,
    ST_WB
  } state_t;

endpackage

`default_nettype wire

/* sv/achb_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
`default_nettype none

module achb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* sv/achb_cfg.sv */
// Register file of the histogram binner behind an APB-style port.
`default_nettype none

module achb_cfg
  import achb_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready,
  output cfg_regs_t               regs
);

  logic signed [SAMPLE_W-1:0] range_low_r;
  logic [BINW_W-1:0]          bin_width_r;
  logic [LIMIT_W-1:0]         count_limit_r;
  logic                       wr;
  reg_idx_t                   idx;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;
  assign idx    = reg_idx_t'(paddr[3:2]);

  // Register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_low_r   <= RANGE_LOW_RST;
      bin_width_r   <= BIN_WIDTH_RST;
      count_limit_r <= COUNT_LIMIT_RST;
    end else if (wr) begin
      unique case (idx)
        REG_RANGE_LOW:   range_low_r   <= $signed(pwdata);
        REG_BIN_WIDTH:   bin_width_r   <= pwdata[BINW_W-1:0];
        REG_COUNT_LIMIT: count_limit_r <= pwdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Read-back multiplexer.
  always_comb begin
    unique case (idx)
      REG_RANGE_LOW:   prdata = range_low_r;
      REG_BIN_WIDTH:   prdata = PDATA_W'(bin_width_r);
      REG_COUNT_LIMIT: prdata = PDATA_W'(count_limit_r);
      default:         prdata = '0;
    endcase
  end

  // A change of either bin edge restarts the sample counter.
  always_comb begin
    regs.range_low   = range_low_r;
    regs.bin_width   = bin_width_r;
    regs.count_limit = count_limit_r;
    regs.edges_wr    = wr & ((idx == REG_RANGE_LOW) || (idx == REG_BIN_WIDTH));
  end

endmodule

`default_nettype wire

/* sv/achb_div.sv */
// Iterative restoring divider that yields one bin-index bit per cycle.
`default_nettype none

module achb_div
  import achb_pkg::*;
#(
  parameter int AW = 6,
  parameter int DW = 32
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [DW-1:0]     num,
  input  wire logic [BINW_W-1:0] den,
  output logic                   done,
  output logic      [AW-1:0]     quot
);

  logic [DW-1:0] num_r;
  logic [DW-1:0] dvs_r;
  logic [AW:0]   q_r;
  logic          run_r;
  logic          bit_q;
  logic [AW:0]   q_nxt;

  // The quotient is known to stay below 2^AW, so the divisor starts shifted
  // up by AW-1 places and a marker bit in the quotient register counts steps.
  assign bit_q = (num_r >= dvs_r);
  assign q_nxt = {q_r[AW-1:0], bit_q};
  assign done  = run_r & q_nxt[AW];
  assign quot  = q_nxt[AW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
    end else if (start) begin
      run_r <= 1'b1;
    end else if (done) begin
      run_r <= 1'b0;
    end
  end

  // Shift-and-subtract step.
  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      dvs_r <= DW'(den) << (AW - 1);
      q_r   <= (AW+1)'(1);
    end else if (run_r) begin
      if (bit_q) begin
        num_r <= num_r - dvs_r;
      end
      dvs_r <= dvs_r >> 1;
      q_r   <= q_nxt;
    end
  end

endmodule

`default_nettype wire

/* sv/auto_clearing_histogram_binner.sv */
// Top level of the auto-clearing histogram binner: sequencer, count store and word registers.
//
// Sorts signed Q16.16 samples into BINS uniform bins with clamped ends and keeps
// a 17-bit saturating count per bin in a RAM, together with a peak count and a
// sample counter. A read word returns one bin's count. Words are handled one at
// a time: a read passes through PREP, RD and WB, a clamped sample through PREP,
// RANGE, RD and WB, and a sample inside the range also through DIV, because its
// bin number comes from a divider that resolves one bit per cycle. The write-back
// waits while the previous result is still held by out_stall. Each count is
// stored with a clear tag, so an automatic clear only steps the tag; on every
// sixteenth clear the tag wraps and the RAM is swept. After reset the same sweep
// runs before the first word is taken; register writes are accepted throughout.
`default_nettype none

module auto_clearing_histogram_binner
  import achb_pkg::*;
#(
  parameter int BINS = BINS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire in_word_t           in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output out_word_t               out_data,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready
);

  localparam int AW    = (BINS > 1) ? $clog2(BINS) : 1;
  localparam int DW    = BINW_W + AW;
  localparam int EW    = AW + 34;
  localparam int MEM_W = EPOCH_W + CNT_W;

  cfg_regs_t regs;

  state_t state_r, state_nxt;

  in_word_t                in_r;
  logic signed [EW-1:0]    diff_r;
  logic [EW-1:0]           span_r;
  logic                    below_r;
  logic                    in_range_r;
  logic [AW-1:0]           idx_r;
  logic                    clr_r;
  logic [CNT_W-1:0]        peak_r;
  logic [CNT_W-1:0]        seen_r;
  logic [EPOCH_W-1:0]      epoch_r;
  logic [AW-1:0]           sweep_cnt_r;
  logic                    pend_r;
  logic                    out_valid_r;
  out_word_t               out_r;

  logic                    accept;
  logic                    out_free;
  logic                    need_clear;
  logic                    epoch_wrap;
  logic                    sweep_last;
  logic                    is_above;
  logic                    is_low;
  logic                    div_start;
  logic                    div_done;
  logic [AW-1:0]           div_quot;
  logic                    wb_fire;
  logic                    ram_we;
  logic [AW-1:0]           ram_waddr;
  logic [MEM_W-1:0]        ram_wdata;
  logic [MEM_W-1:0]        ram_rdata;
  logic [CNT_W-1:0]        cur_cnt;
  logic [CNT_W-1:0]        new_cnt;
  logic [CNT_W-1:0]        new_peak;

  // Register file.
  achb_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .regs    (regs)
  );

  // Bin number of a sample that lies inside the range.
  achb_div #(
    .AW (AW),
    .DW (DW)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (DW'(diff_r - EW'(1))),
    .den   (regs.bin_width),
    .done  (div_done),
    .quot  (div_quot)
  );

  // Count store: clear tag above the saturating count.
  achb_ram #(
    .WIDTH (MEM_W),
    .DEPTH (BINS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (idx_r),
    .rdata (ram_rdata)
  );

  // Handshake and decode terms.
  assign in_stall   = (state_r != ST_IDLE);
  assign accept     = in_valid & ~in_stall;
  assign out_free   = ~out_valid_r | ~out_stall;
  assign need_clear = (seen_r > CNT_W'(regs.count_limit));
  assign epoch_wrap = (epoch_r == {EPOCH_W{1'b1}});
  assign sweep_last = (sweep_cnt_r == AW'(BINS - 1));
  assign is_low     = below_r | (diff_r == '0);
  assign is_above   = (diff_r > $signed(span_r));
  assign div_start  = (state_r == ST_RANGE) & ~is_low & ~is_above;
  assign wb_fire    = (state_r == ST_WB) & out_free;

  // A count whose tag is stale belongs to a cleared generation and reads as zero.
  assign cur_cnt  = (ram_rdata[MEM_W-1:CNT_W] == epoch_r) ? ram_rdata[CNT_W-1:0] : '0;
  assign new_cnt  = (cur_cnt < COUNT_MAX) ? (cur_cnt + CNT_W'(1)) : cur_cnt;
  assign new_peak = (new_cnt > peak_r) ? new_cnt : peak_r;

  // Store write port: the sweep clears entries, the write-back stores a count.
  always_comb begin
    if (state_r == ST_SWEEP) begin
      ram_we    = 1'b1;
      ram_waddr = sweep_cnt_r;
      ram_wdata = '0;
    end else begin
      ram_we    = wb_fire & (in_r.kind == KIND_SAMPLE);
      ram_waddr = idx_r;
      ram_wdata = {epoch_r, new_cnt};
    end
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_SWEEP;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_SWEEP: begin
        if (sweep_last) begin
          state_nxt = pend_r ? ST_RANGE : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        if (in_r.kind == KIND_READ) begin
          state_nxt = ST_RD;
        end else if (need_clear && epoch_wrap) begin
          state_nxt = ST_SWEEP;
        end else begin
          state_nxt = ST_RANGE;
        end
      end
      ST_RANGE: begin
        state_nxt = div_start ? ST_DIV : ST_RD;
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_RD;
        end
      end
      ST_RD: begin
        state_nxt = ST_WB;
      end
      ST_WB: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers: sweep, clear tag, peak and sample counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_cnt_r <= '0;
      pend_r      <= 1'b0;
      epoch_r     <= '0;
      peak_r      <= '0;
      seen_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == ST_SWEEP) begin
        sweep_cnt_r <= sweep_cnt_r + AW'(1);
        if (sweep_last) begin
          pend_r <= 1'b0;
        end
      end

      if (regs.edges_wr) begin
        seen_r <= '0;
      end else if ((state_r == ST_PREP) && (in_r.kind == KIND_SAMPLE)) begin
        if (need_clear) begin
          seen_r <= CNT_W'(1);
          peak_r <= '0;
          if (epoch_wrap) begin
            epoch_r     <= '0;
            sweep_cnt_r <= '0;
            pend_r      <= 1'b1;
          end else begin
            epoch_r <= epoch_r + EPOCH_W'(1);
          end
        end else begin
          seen_r <= seen_r + CNT_W'(1);
        end
      end

      if (wb_fire && (in_r.kind == KIND_SAMPLE)) begin
        peak_r <= new_peak;
      end

      if (wb_fire) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers: accepted word, edge terms and bin number.
  always_ff @(posedge clk) begin
    if (accept) begin
      in_r <= in_data;
    end

    if (state_r == ST_PREP) begin
      diff_r     <= EW'(in_r.sample_value) - EW'(regs.range_low);
      span_r     <= EW'(BINS) * EW'(regs.bin_width);
      below_r    <= (in_r.sample_value < regs.range_low);
      clr_r      <= (in_r.kind == KIND_SAMPLE) & need_clear;
      in_range_r <= (32'(in_r.bin_select) < 32'(BINS));
      idx_r      <= AW'(in_r.bin_select);
    end

    // Clamped ends bypass the divider.
    if (state_r == ST_RANGE) begin
      if (is_low) begin
        idx_r <= '0;
      end else if (is_above) begin
        idx_r <= AW'(BINS - 1);
      end
    end

    if ((state_r == ST_DIV) && div_done) begin
      idx_r <= div_quot;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (wb_fire) begin
      out_r.bin_index <= SEL_W'(idx_r);
      if (in_r.kind == KIND_READ) begin
        out_r.bin_count  <= in_range_r ? cur_cnt : '0;
        out_r.peak_count <= peak_r;
        out_r.cleared    <= 1'b0;
      end else begin
        out_r.bin_count  <= new_cnt;
        out_r.peak_count <= new_peak;
        out_r.cleared    <= clr_r;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

/* dv/tb_auto_clearing_histogram_binner.sv */
// Self-checking testbench for the auto-clearing histogram binner.
module tb_auto_clearing_histogram_binner;
  timeunit 1ns;
  timeprecision 1ps;

  import achb_pkg::*;

  // Cycles without any accepted word, taken result or register access before the run is abandoned.
  localparam int QUIET_LIMIT = 4000;
  localparam int GAP_MAX     = 18;
  localparam int DRAIN_WAIT  = 20;

  logic                 clk;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  in_word_t             in_data   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_word_t            out_data;
  logic                 psel      = 1'b0;
  logic                 penable   = 1'b0;
  logic                 pwrite    = 1'b0;
  logic [PADDR_W-1:0]   paddr     = '0;
  logic [PDATA_W-1:0]   pwdata    = '0;
  logic [PDATA_W-1:0]   prdata;
  logic                 pready;

  auto_clearing_histogram_binner dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Predicted histogram state and register copies.
  logic [CNT_W-1:0]           tally [BINS_DEF];
  logic [CNT_W-1:0]           tally_peak;
  logic [CNT_W-1:0]           seen_count;
  logic signed [SAMPLE_W-1:0] cfg_low;
  logic [BINW_W-1:0]          cfg_width;
  logic [LIMIT_W-1:0]         cfg_limit;

  // Results still owed by the block, oldest first.
  out_word_t pending_bins[$];

  int errors        = 0;
  int results_taken = 0;
  bit idle_on       = 1'b1;

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Bin chosen for a sample under the current edges, in exact wide arithmetic.
  function automatic int bin_of(logic signed [SAMPLE_W-1:0] v);
    longint val, lo, wd, top, d;
    val = longint'(v);
    lo  = longint'(cfg_low);
    wd  = longint'(cfg_width);
    top = lo + BINS_DEF * wd;
    if (val < lo) return 0;
    if (val > top) return BINS_DEF - 1;
    d = val - lo;
    if (d == 0 || wd == 0) return 0;
    d = (d - 1) / wd;
    return (d > BINS_DEF - 1) ? BINS_DEF - 1 : int'(d);
  endfunction

  // Advances the predicted histogram by one word and returns the result it owes.
  function automatic out_word_t histogram_predict(in_word_t w);
    out_word_t r;
    int        b;
    r = '0;
    if (w.kind == KIND_READ) begin
      r.bin_index = w.bin_select;
      r.bin_count = tally[w.bin_select];
    end else begin
      // Once the counter has passed the limit, the store and the peak start afresh.
      if (seen_count > {1'b0, cfg_limit}) begin
        foreach (tally[i]) tally[i] = '0;
        tally_peak = '0;
        seen_count = '0;
        r.cleared  = 1'b1;
      end
      seen_count = seen_count + CNT_W'(1);
      b = bin_of(w.sample_value);
      if (tally[b] < COUNT_MAX) tally[b] = tally[b] + CNT_W'(1);
      if (tally[b] > tally_peak) tally_peak = tally[b];
      r.bin_index = b[SEL_W-1:0];
      r.bin_count = tally[b];
    end
    r.peak_count = tally_peak;
    return r;
  endfunction

  // State after reset.
  function automatic void histogram_reset();
    foreach (tally[i]) tally[i] = '0;
    tally_peak = '0;
    seen_count = '0;
    cfg_low    = RANGE_LOW_RST;
    cfg_width  = BIN_WIDTH_RST;
    cfg_limit  = COUNT_LIMIT_RST;
  endfunction

  // A new range or width restarts the sample counter but keeps the counts.
  function automatic void histogram_config(reg_idx_t idx, logic [PDATA_W-1:0] val);
    case (idx)
      REG_RANGE_LOW: begin
        cfg_low    = val;
        seen_count = '0;
      end
      REG_BIN_WIDTH: begin
        cfg_width  = val[BINW_W-1:0];
        seen_count = '0;
      end
      REG_COUNT_LIMIT: begin
        cfg_limit = val[LIMIT_W-1:0];
      end
      default: begin
      end
    endcase
  endfunction

  // Register write followed by a read back of the same register.
  task automatic reg_write(reg_idx_t idx, logic [PDATA_W-1:0] val);
    logic [PDATA_W-1:0] mask, got;
    mask = (idx == REG_BIN_WIDTH)   ? 32'h03FF_FFFF :
           (idx == REG_COUNT_LIMIT) ? 32'h0000_FFFF : 32'hFFFF_FFFF;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    histogram_config(idx, val);
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    got = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if ((got & mask) !== (val & mask)) begin
      errors++;
      if (errors <= 10)
        $display("register %s read back: expected %h, got %h", idx.name(), val & mask,
                 got & mask);
    end
  endtask

  // Offers one word, after a random gap while idling is on, and records its result once it is taken.
  task automatic send_word(in_word_t w);
    int gap;
    gap = idle_on ? $urandom_range(0, GAP_MAX) : 0;
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall !== 1'b0);
    pending_bins.push_back(histogram_predict(w));
  endtask

  task automatic push_sample(longint v);
    in_word_t w;
    w.kind         = KIND_SAMPLE;
    w.sample_value = v[SAMPLE_W-1:0];
    w.bin_select   = SEL_W'($urandom_range(0, BINS_DEF - 1));
    send_word(w);
  endtask

  task automatic push_read(int sel);
    in_word_t w;
    w.kind         = KIND_READ;
    w.sample_value = $urandom;
    w.bin_select   = sel[SEL_W-1:0];
    send_word(w);
  endtask

  // Stops offering words and waits for every owed result.
  task automatic quiesce();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_bins.size() != 0) @(posedge clk);
  endtask

  // Sample spread over the bins, their edges and the whole field.
  function automatic longint pick_sample();
    longint lo, wd;
    int     k, j;
    lo = longint'(cfg_low);
    wd = longint'(cfg_width);
    case ($urandom_range(0, 7))
      0: return longint'($urandom);
      1, 2: begin
        k = $urandom_range(0, BINS_DEF + 1);
        j = $urandom_range(0, 2);
        return lo + k * wd + j - 1;
      end
      default: return lo - wd + (longint'($urandom) % (66 * wd + 1));
    endcase
  endfunction

  // Edges of the reset-time bins, both clamped ends and both field extremes.
  task automatic test_reset_edges();
    longint lo, wd, top;
    lo  = longint'(RANGE_LOW_RST);
    wd  = longint'(BIN_WIDTH_RST);
    top = lo + BINS_DEF * wd;
    push_sample(lo - 1);
    push_sample(lo);
    push_sample(lo + wd);
    push_sample(lo + wd + 1);
    push_sample(lo + 32 * wd);
    push_sample(top);
    push_sample(top + 1);
    push_sample(longint'(32'h7FFF_FFFF));
    push_sample(-longint'(32'h8000_0000));
    push_read(0);
    push_read(BINS_DEF - 1);
    push_read(1);
    quiesce();
  endtask

  // With no width every edge sits on the lower limit.
  task automatic test_zero_width();
    longint lo;
    lo = longint'(cfg_low);
    reg_write(REG_BIN_WIDTH, '0);
    push_sample(lo);
    push_sample(lo + 1);
    push_sample(lo - 1);
    quiesce();
  endtask

  // A small limit makes the store clear itself every few samples.
  task automatic test_auto_clear();
    reg_write(REG_BIN_WIDTH, 32'(BIN_WIDTH_RST));
    reg_write(REG_COUNT_LIMIT, 32'd1);
    repeat (5) push_sample(pick_sample());
    push_read($urandom_range(0, BINS_DEF - 1));
    quiesce();
  endtask

  // Phases of random words under changing registers and idling.
  task automatic test_random_phases();
    logic [PDATA_W-1:0] lo, wd, lim;
    int                 t;
    for (int p = 0; p < 12; p++) begin
      quiesce();
      case (p)
        0: begin
          lo  = 32'h8000_0000;
          wd  = 32'd33554432;
          lim = 32'd0;
        end
        1: begin
          lo  = 32'hC000_0000;
          wd  = 32'h03FF_FFFF;
          lim = 32'd65535;
        end
        2: begin
          lo  = $urandom;
          wd  = 32'd1;
          lim = $urandom_range(0, 20);
        end
        default: begin
          t   = $urandom_range(0, 2097152);
          lo  = $urandom_range(0, 1) ? $urandom : 32'(t - 1048576);
          wd  = $urandom_range(0, 1) ? $urandom_range(1, 33554432) : $urandom_range(1, 4096);
          wd  = wd | ($urandom & 32'hFC00_0000);
          lim = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 100);
          lim = lim | ($urandom & 32'hFFFF_0000);
        end
      endcase
      if (p % 4 != 3) begin
        reg_write(REG_RANGE_LOW, lo);
        reg_write(REG_BIN_WIDTH, wd);
      end
      reg_write(REG_COUNT_LIMIT, lim);
      idle_on = (p % 3 != 1);
      for (int n = 0; n < 125; n++) begin
        // Now and then the sender holds off until the block has caught up.
        if (n == 60 && p % 2 == 0) quiesce();
        if ($urandom_range(0, 4) == 0) push_read($urandom_range(0, BINS_DEF - 1));
        else push_sample(pick_sample());
      end
    end
    quiesce();
  endtask

  // Piles samples into bin 0, then restarts the counter so that it does not clear.
  task automatic test_one_bin();
    idle_on = 1'b0;
    reg_write(REG_RANGE_LOW, 32'h7FFF_FFFF);
    reg_write(REG_COUNT_LIMIT, 32'd65535);
    repeat (60) push_sample(longint'($urandom));
    quiesce();
    reg_write(REG_RANGE_LOW, 32'h7FFF_FFFF);
    repeat (3) push_sample(longint'($urandom));
    push_read(0);
    quiesce();
  endtask

  // Each result taken is compared with the oldest one owed.
  always @(posedge clk) begin : check_results
    out_word_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      results_taken = results_taken + 1;
      if (pending_bins.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result at %0t: bin %0d count %0d peak %0d cleared %0b",
                   $time, out_data.bin_index, out_data.bin_count, out_data.peak_count,
                   out_data.cleared);
      end else begin
        want = pending_bins.pop_front();
        if (out_data.bin_index !== want.bin_index || out_data.bin_count !== want.bin_count ||
            out_data.peak_count !== want.peak_count || out_data.cleared !== want.cleared) begin
          errors++;
          if (errors <= 10)
            $display("mismatch at %0t: expected bin %0d count %0d peak %0d cleared %0b, %s",
                     $time, want.bin_index, want.bin_count, want.peak_count, want.cleared,
                     $sformatf("got bin %0d count %0d peak %0d cleared %0b",
                               out_data.bin_index, out_data.bin_count, out_data.peak_count,
                               out_data.cleared));
        end
      end
    end
  end

  // While idling is on, the receiver holds each result back for a random number of cycles.
  int rx_hold = 0;
  int rx_seen = 0;
  always @(negedge clk) begin
    if (rx_seen != results_taken) begin
      rx_seen = results_taken;
      rx_hold = idle_on ? $urandom_range(0, GAP_MAX) : 0;
    end
    if (rx_hold > 0) begin
      out_stall <= 1'b1;
      if (out_valid === 1'b1) rx_hold--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Gives up when nothing moves on any port for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid === 1'b1 && in_stall === 1'b0) ||
          (out_valid === 1'b1 && out_stall === 1'b0) ||
          (psel === 1'b1 && penable === 1'b1 && pready === 1'b1))
        quiet = 0;
      else
        quiet++;
    end
    $display("tb_auto_clearing_histogram_binner NOT OK");
    $finish;
  end

  // Test sequence.
  initial begin
    histogram_reset();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_reset_edges();
    test_zero_width();
    test_auto_clear();
    test_random_phases();
    test_one_bin();
    quiesce();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (pending_bins.size() != 0) errors++;
    if (errors == 0) begin
      $display("tb_auto_clearing_histogram_binner OK");
    end else begin
      $display("tb_auto_clearing_histogram_binner NOT OK");
    end
    $finish;
  end

endmodule
